FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_CLK(lbl, clk, prop, msg)
`endif
`endif

FILE: rtl/core/qvr_pkg.sv
// ----------------------------------------------------------------------------
// qvr_pkg
// shared constants and types of the quaternion vector rotation block
// ----------------------------------------------------------------------------
package qvr_pkg;

    localparam int QUAT_WIDTH_DEF = 16;
    localparam int VEC_WIDTH_DEF  = 32;

    localparam logic CMD_FWD = 1'b0;
    localparam logic CMD_REV = 1'b1;

    typedef struct packed {
        logic       zero;
        logic [2:0] neg;
        logic [2:0] ovf;
    } t_ctrl;

endpackage

FILE: rtl/core/qvr_if.sv
// ----------------------------------------------------------------------------
// qvr_if
// request and result channels of the quaternion vector rotation block
// ----------------------------------------------------------------------------
interface qvr_in_if #(
    parameter int QUAT_WIDTH = qvr_pkg::QUAT_WIDTH_DEF,
    parameter int VEC_WIDTH  = qvr_pkg::VEC_WIDTH_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic signed [QUAT_WIDTH-1:0] quat_w;
    logic signed [QUAT_WIDTH-1:0] quat_x;
    logic signed [QUAT_WIDTH-1:0] quat_y;
    logic signed [QUAT_WIDTH-1:0] quat_z;
    logic signed [VEC_WIDTH-1:0]  vec_x;
    logic signed [VEC_WIDTH-1:0]  vec_y;
    logic signed [VEC_WIDTH-1:0]  vec_z;

    modport source (
        output valid, command, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
        input  ready
    );
    modport sink (
        input  valid, command, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
        output ready
    );
endinterface

interface qvr_out_if #(
    parameter int VEC_WIDTH = qvr_pkg::VEC_WIDTH_DEF
) ();
    logic                        valid;
    logic                        ready;
    logic signed [VEC_WIDTH-1:0] out_x;
    logic signed [VEC_WIDTH-1:0] out_y;
    logic signed [VEC_WIDTH-1:0] out_z;
    logic                        zero_norm;
    logic                        saturated;

    modport source (
        output valid, out_x, out_y, out_z, zero_norm, saturated,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_z, zero_norm, saturated,
        output ready
    );
endinterface

FILE: rtl/core/qvr_divider.sv
// ----------------------------------------------------------------------------
// qvr_divider
// pipelined restoring divide of three numerators by the quaternion norm,
// one quotient bit per stage, with rounding and saturation
// ----------------------------------------------------------------------------
module qvr_divider #(
    parameter int QUAT_WIDTH = qvr_pkg::QUAT_WIDTH_DEF,
    parameter int VEC_WIDTH  = qvr_pkg::VEC_WIDTH_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_en,
    input  logic                                         i_valid,
    input  logic                                         i_zero,
    input  logic [2*QUAT_WIDTH:0]                        i_norm,
    input  logic [2:0][2*QUAT_WIDTH+VEC_WIDTH+4:0]       i_num,
    output logic                                         o_valid,
    output logic                                         o_zero,
    output logic                                         o_sat,
    output logic [2:0][VEC_WIDTH-1:0]                    o_vec
);

    localparam int NUM_W = 2*QUAT_WIDTH + VEC_WIDTH + 5;
    localparam int NN_W  = NUM_W + 1;
    localparam int D_W   = 2*QUAT_WIDTH + 2;
    localparam int TOP_W = NN_W - (VEC_WIDTH + 1);
    localparam int S     = VEC_WIDTH + 2;
    localparam logic [VEC_WIDTH:0] LIM_POS = {2'b00, {(VEC_WIDTH-1){1'b1}}};
    localparam logic [VEC_WIDTH:0] LIM_NEG = {2'b01, {(VEC_WIDTH-1){1'b0}}};

    logic                       r_vld [S];
    qvr_pkg::t_ctrl             r_ctl [S];
    logic [D_W-1:0]             r_d   [S];
    logic [2:0][D_W-1:0]        r_rem [S];
    logic [2:0][VEC_WIDTH:0]    r_low [S];

    // entry: magnitude, rounding offset, overflow precheck
    logic [2:0]                 n_neg;
    logic [2:0]                 n_ovf;
    logic [2:0][NUM_W-1:0]      n_mag;
    logic [2:0][NN_W-1:0]       n_full;
    logic [2:0][TOP_W-1:0]      n_top;
    logic [D_W-1:0]             n_d;

    always_comb begin
        n_d = {i_norm, 1'b0};
        for (int l = 0; l < 3; l++) begin
            n_neg[l]  = i_num[l][NUM_W-1];
            n_mag[l]  = n_neg[l] ? (~i_num[l] + 1'b1) : i_num[l];
            n_full[l] = {n_mag[l], 1'b0} + NN_W'(i_norm);
            n_top[l]  = n_full[l][NN_W-1:VEC_WIDTH+1];
            n_ovf[l]  = n_top[l] >= TOP_W'(n_d);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl[0].zero <= i_zero;
            r_ctl[0].neg  <= n_neg;
            r_ctl[0].ovf  <= n_ovf;
            r_d[0]        <= n_d;
            for (int l = 0; l < 3; l++) begin
                r_rem[0][l] <= n_top[l][D_W-1:0];
                r_low[0][l] <= n_full[l][VEC_WIDTH:0];
            end
        end
    end

    for (genvar k = 1; k < S; k++) begin : g_step
        logic [2:0][D_W-1:0]      n_rem;
        logic [2:0][VEC_WIDTH:0]  n_low;
        logic [2:0][D_W:0]        n_try;
        logic [2:0][D_W:0]        n_diff;
        logic [2:0]               n_ge;

        always_comb begin
            for (int l = 0; l < 3; l++) begin
                n_try[l]  = {r_rem[k-1][l], r_low[k-1][l][VEC_WIDTH]};
                n_ge[l]   = n_try[l] >= {1'b0, r_d[k-1]};
                n_diff[l] = n_try[l] - {1'b0, r_d[k-1]};
                n_rem[l]  = n_ge[l] ? n_diff[l][D_W-1:0] : n_try[l][D_W-1:0];
                n_low[l]  = {r_low[k-1][l][VEC_WIDTH-1:0], n_ge[l]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ctl[k] <= r_ctl[k-1];
                r_d[k]   <= r_d[k-1];
                r_rem[k] <= n_rem;
                r_low[k] <= n_low;
            end
        end
    end

    // output: clip, restore sign, clear the result for a zero norm
    logic                       r_ovld;
    logic                       r_ozero;
    logic                       r_osat;
    logic [2:0][VEC_WIDTH-1:0]  r_ovec;
    logic [2:0]                 n_clip;
    logic [2:0][VEC_WIDTH:0]    n_lim;
    logic [2:0][VEC_WIDTH-1:0]  n_m;
    logic [2:0][VEC_WIDTH-1:0]  n_vec;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_lim[l]  = r_ctl[S-1].neg[l] ? LIM_NEG : LIM_POS;
            n_clip[l] = r_ctl[S-1].ovf[l] || (r_low[S-1][l] > n_lim[l]);
            n_m[l]    = n_clip[l] ? n_lim[l][VEC_WIDTH-1:0] : r_low[S-1][l][VEC_WIDTH-1:0];
            n_vec[l]  = r_ctl[S-1].neg[l] ? (~n_m[l] + 1'b1) : n_m[l];
            if (r_ctl[S-1].zero) begin
                n_vec[l] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (i_en) begin
            r_ovld <= r_vld[S-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ozero <= r_ctl[S-1].zero;
            r_osat  <= (|n_clip) && !r_ctl[S-1].zero;
            r_ovec  <= n_vec;
        end
    end

    assign o_valid = r_ovld;
    assign o_zero  = r_ozero;
    assign o_sat   = r_osat;
    assign o_vec   = r_ovec;

endmodule

FILE: rtl/core/quaternion_vector_rotation.sv
// ----------------------------------------------------------------------------
// quaternion_vector_rotation
// rotates a fixed point vector by a quaternion, forward or reverse
// result path: stages 1 to 4, then the divider steps and its output register
// throughput: one request per cycle unless the skid entry is full; fully pipelined
// a skid entry behind the result register holds a stalled result, then ready drops
// reset clears all valid bits; payload registers are not reset
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module quaternion_vector_rotation #(
    parameter int QUAT_WIDTH = qvr_pkg::QUAT_WIDTH_DEF,
    parameter int VEC_WIDTH  = qvr_pkg::VEC_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    qvr_in_if.sink     i_in,
    qvr_out_if.source  o_out
);

    localparam int QW    = QUAT_WIDTH;
    localparam int VW    = VEC_WIDTH;
    localparam int SQ_W  = 2*QW + 2;
    localparam int NRM_W = 2*QW + 1;
    localparam int A_W   = 2*QW + 1;
    localparam int P_W   = QW + VW;
    localparam int DOT_W = QW + VW + 2;
    localparam int C_W   = QW + VW + 1;
    localparam int TW_W  = QW + 2;
    localparam int NUM_W = 2*QW + VW + 5;

    logic w_en;
    logic r_skid_vld;

    assign w_en       = !r_skid_vld;
    assign i_in.ready = w_en;

    logic signed [QW-1:0] w_u [3];
    logic signed [VW-1:0] w_v [3];

    assign w_u[0] = i_in.quat_x;
    assign w_u[1] = i_in.quat_y;
    assign w_u[2] = i_in.quat_z;
    assign w_v[0] = i_in.vec_x;
    assign w_v[1] = i_in.vec_y;
    assign w_v[2] = i_in.vec_z;

    // stage 1: squares and quaternion by vector component products
    logic                   r1_vld;
    logic                   r1_cmd;
    logic signed [QW-1:0]   r1_w;
    logic signed [QW-1:0]   r1_u [3];
    logic signed [VW-1:0]   r1_v [3];
    logic signed [2*QW-1:0] r1_ww;
    logic signed [2*QW-1:0] r1_uu [3];
    logic signed [P_W-1:0]  r1_p  [3][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_cmd <= i_in.command;
            r1_w   <= i_in.quat_w;
            r1_ww  <= i_in.quat_w * i_in.quat_w;
            for (int i = 0; i < 3; i++) begin
                r1_u[i]  <= w_u[i];
                r1_v[i]  <= w_v[i];
                r1_uu[i] <= w_u[i] * w_u[i];
                for (int j = 0; j < 3; j++) begin
                    r1_p[i][j] <= w_u[i] * w_v[j];
                end
            end
        end
    end

    // stage 2: norm, scalar term, dot and cross
    logic signed [SQ_W-1:0]  n_norm_full;
    logic signed [SQ_W-1:0]  n_a_full;
    logic signed [DOT_W-1:0] n_dot_sum;
    logic signed [TW_W-1:0]  n_w_ext;
    logic signed [TW_W-1:0]  n_w2;

    always_comb begin
        n_norm_full = SQ_W'(r1_ww) + SQ_W'(r1_uu[0]) + SQ_W'(r1_uu[1]) + SQ_W'(r1_uu[2]);
        n_a_full    = SQ_W'(r1_ww) - SQ_W'(r1_uu[0]) - SQ_W'(r1_uu[1]) - SQ_W'(r1_uu[2]);
        n_dot_sum   = DOT_W'(r1_p[0][0]) + DOT_W'(r1_p[1][1]) + DOT_W'(r1_p[2][2]);
        n_w_ext     = TW_W'(r1_w);
        n_w2        = n_w_ext <<< 1;
    end

    logic                    r2_vld;
    logic                    r2_zero;
    logic [NRM_W-1:0]        r2_norm;
    logic signed [A_W-1:0]   r2_a;
    logic signed [DOT_W-1:0] r2_dot;
    logic signed [C_W-1:0]   r2_c [3];
    logic signed [TW_W-1:0]  r2_tw;
    logic signed [QW-1:0]    r2_u [3];
    logic signed [VW-1:0]    r2_v [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_zero <= (n_norm_full == '0);
            r2_norm <= n_norm_full[NRM_W-1:0];
            r2_a    <= n_a_full[A_W-1:0];
            r2_dot  <= {n_dot_sum[DOT_W-2:0], 1'b0};
            r2_c[0] <= C_W'(r1_p[1][2]) - C_W'(r1_p[2][1]);
            r2_c[1] <= C_W'(r1_p[2][0]) - C_W'(r1_p[0][2]);
            r2_c[2] <= C_W'(r1_p[0][1]) - C_W'(r1_p[1][0]);
            r2_tw   <= (r1_cmd == qvr_pkg::CMD_REV) ? -n_w2 : n_w2;
            r2_u    <= r1_u;
            r2_v    <= r1_v;
        end
    end

    // stage 3: term products
    logic                         r3_vld;
    logic                         r3_zero;
    logic [NRM_W-1:0]             r3_norm;
    logic signed [A_W+VW-1:0]     r3_av [3];
    logic signed [DOT_W+QW-1:0]   r3_du [3];
    logic signed [TW_W+C_W-1:0]   r3_tc [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_zero <= r2_zero;
            r3_norm <= r2_norm;
            for (int i = 0; i < 3; i++) begin
                r3_av[i] <= r2_a * r2_v[i];
                r3_du[i] <= r2_dot * r2_u[i];
                r3_tc[i] <= r2_tw * r2_c[i];
            end
        end
    end

    // stage 4: numerators
    logic                   r4_vld;
    logic                   r4_zero;
    logic [NRM_W-1:0]       r4_norm;
    logic [2:0][NUM_W-1:0]  r4_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (w_en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_zero <= r3_zero;
            r4_norm <= r3_norm;
            for (int i = 0; i < 3; i++) begin
                r4_num[i] <= NUM_W'(r3_av[i]) + NUM_W'(r3_du[i]) + NUM_W'(r3_tc[i]);
            end
        end
    end

    logic                   w_dvld;
    logic                   w_dzero;
    logic                   w_dsat;
    logic [2:0][VW-1:0]     w_dvec;

    qvr_divider #(
        .QUAT_WIDTH (QUAT_WIDTH),
        .VEC_WIDTH  (VEC_WIDTH)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r4_vld),
        .i_zero  (r4_zero),
        .i_norm  (r4_norm),
        .i_num   (r4_num),
        .o_valid (w_dvld),
        .o_zero  (w_dzero),
        .o_sat   (w_dsat),
        .o_vec   (w_dvec)
    );

    // skid entry behind the result register
    logic               r_sk_zero;
    logic               r_sk_sat;
    logic [2:0][VW-1:0] r_sk_vec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (o_out.ready) begin
                r_skid_vld <= 1'b0;
            end
        end else if (w_dvld && !o_out.ready) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_vld) begin
            r_sk_zero <= w_dzero;
            r_sk_sat  <= w_dsat;
            r_sk_vec  <= w_dvec;
        end
    end

    assign o_out.valid     = r_skid_vld || w_dvld;
    assign o_out.zero_norm = r_skid_vld ? r_sk_zero : w_dzero;
    assign o_out.saturated = r_skid_vld ? r_sk_sat  : w_dsat;
    assign o_out.out_x     = r_skid_vld ? r_sk_vec[0] : w_dvec[0];
    assign o_out.out_y     = r_skid_vld ? r_sk_vec[1] : w_dvec[1];
    assign o_out.out_z     = r_skid_vld ? r_sk_vec[2] : w_dvec[2];

    `ASSERT_CLK(a_reset_clears_out, i_clk,
        !i_rst_n |=> !o_out.valid, "result valid after reset")
    `ASSERT_CLK_RST(a_skid_fill, i_clk, i_rst_n,
        $rose(r_skid_vld) |-> $past(o_out.valid && !o_out.ready),
        "skid filled without stall")
    `ASSERT_CLK_RST(a_skid_hold, i_clk, i_rst_n,
        (r_skid_vld && !o_out.ready) |=> r_skid_vld, "skid dropped a stalled result")
    `ASSERT_CLK_RST(a_zero_out, i_clk, i_rst_n,
        (o_out.valid && o_out.zero_norm) |-> (!o_out.saturated && o_out.out_x == '0
            && o_out.out_y == '0 && o_out.out_z == '0),
        "zero quaternion result not cleared")

endmodule
